@@ design/lrt_pkg.sv @@
// Shared types, constants and status codes of the LRU replacement tracker.
package lrt_pkg;

    localparam int KEY_BITS    = 32;
    localparam int ENTRIES_DEF = 16;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_EVICTED  = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    localparam logic MODE_TOUCH = 1'b0;
    localparam logic MODE_EVICT = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [KEY_BITS-1:0] key;
    } lrt_in_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [KEY_BITS-1:0] evicted_key;
    } lrt_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_CHECK,
        S_DECIDE,
        S_LINK_RD,
        S_RELINK_A,
        S_RELINK_B,
        S_INSERT,
        S_EV_RD,
        S_EV_DO,
        S_RESPOND
    } lrt_state_t;

    typedef struct packed {
        logic       load_item;
        logic       scan;
        logic       relink_a;
        logic       relink_b;
        logic       insert;
        logic       evict_rd;
        logic       evict_do;
        logic       emit;
        logic [2:0] code;
    } lrt_cmd_t;

    typedef struct packed {
        logic item_evict;
        logic empty;
        logic scan_last;
        logic found;
        logic have_free;
        logic hit_newest;
        logic out_free;
    } lrt_sts_t;

endpackage

@@ design/lrt_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module lrt_ram
    import lrt_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/lrt_datapath.sv @@
// Datapath of the LRU replacement tracker: slot stores, list pointers and result register.
module lrt_datapath
    import lrt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  lrt_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output lrt_out_t m_data,
    input  lrt_cmd_t cmd,
    output lrt_sts_t sts
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    lrt_in_t             item_reg;
    logic [IDX_W-1:0]    scan_cnt_reg;
    logic                cmp_vld_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    hit_reg;
    logic                have_free_reg;
    logic [IDX_W-1:0]    free_reg;
    logic [ENTRIES-1:0]  valid_reg;
    logic [IDX_W-1:0]    oldest_reg;
    logic [IDX_W-1:0]    newest_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [KEY_BITS-1:0] victim_reg;
    logic                m_valid_reg;
    lrt_out_t            m_data_reg;

    logic                key_we;
    logic [IDX_W-1:0]    key_raddr;
    logic [KEY_BITS-1:0] key_rdata;
    logic                newer_we;
    logic [IDX_W-1:0]    newer_waddr;
    logic [IDX_W-1:0]    newer_wdata;
    logic [IDX_W-1:0]    newer_rdata;
    logic                older_we;
    logic [IDX_W-1:0]    older_waddr;
    logic [IDX_W-1:0]    older_wdata;
    logic [IDX_W-1:0]    older_rdata;
    logic [IDX_W-1:0]    link_raddr;
    logic                cmp_hit;
    logic                cmp_free;
    logic                not_oldest;
    logic                out_free;

    assign key_raddr  = cmd.evict_rd ? oldest_reg : scan_cnt_reg;
    assign link_raddr = cmd.evict_rd ? oldest_reg : hit_reg;
    assign key_we     = cmd.insert;
    assign not_oldest = (hit_reg != oldest_reg);

    always_comb begin
        newer_we    = 1'b0;
        newer_waddr = newest_reg;
        newer_wdata = hit_reg;
        older_we    = 1'b0;
        older_waddr = hit_reg;
        older_wdata = newest_reg;
        if (cmd.relink_a) begin
            newer_we    = not_oldest;
            newer_waddr = older_rdata;
            newer_wdata = newer_rdata;
            older_we    = not_oldest;
            older_waddr = newer_rdata;
            older_wdata = older_rdata;
        end else if (cmd.relink_b) begin
            newer_we = 1'b1;
            older_we = 1'b1;
        end else if (cmd.insert) begin
            newer_we    = (count_reg != '0);
            newer_wdata = free_reg;
            older_we    = (count_reg != '0);
            older_waddr = free_reg;
        end
    end

    lrt_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (free_reg),
        .wdata (item_reg.key),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    lrt_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_newer_ram (
        .aclk  (aclk),
        .we    (newer_we),
        .waddr (newer_waddr),
        .wdata (newer_wdata),
        .raddr (link_raddr),
        .rdata (newer_rdata)
    );

    lrt_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_older_ram (
        .aclk  (aclk),
        .we    (older_we),
        .waddr (older_waddr),
        .wdata (older_wdata),
        .raddr (link_raddr),
        .rdata (older_rdata)
    );

    assign cmp_hit  = cmp_vld_reg && valid_reg[cmp_idx_reg] && (key_rdata == item_reg.key);
    assign cmp_free = cmp_vld_reg && !valid_reg[cmp_idx_reg];

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        cmp_idx_reg <= scan_cnt_reg;
        if (cmp_hit && !found_reg) begin
            hit_reg <= cmp_idx_reg;
        end
        if (cmp_free && !have_free_reg) begin
            free_reg <= cmp_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cnt_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            have_free_reg <= 1'b0;
            valid_reg     <= '0;
            oldest_reg    <= '0;
            newest_reg    <= '0;
            count_reg     <= '0;
            victim_reg    <= '0;
        end else begin
            cmp_vld_reg <= cmd.scan;
            if (cmd.load_item) begin
                scan_cnt_reg  <= '0;
                found_reg     <= 1'b0;
                have_free_reg <= 1'b0;
                victim_reg    <= '0;
            end else begin
                if (cmd.scan) begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                if (cmp_hit) begin
                    found_reg <= 1'b1;
                end
                if (cmp_free) begin
                    have_free_reg <= 1'b1;
                end
            end
            if (cmd.relink_a && !not_oldest) begin
                oldest_reg <= newer_rdata;
            end
            if (cmd.relink_b) begin
                newest_reg <= hit_reg;
            end
            if (cmd.insert) begin
                valid_reg[free_reg] <= 1'b1;
                newest_reg          <= free_reg;
                count_reg           <= count_reg + 1'b1;
                if (count_reg == '0) begin
                    oldest_reg <= free_reg;
                end
            end
            if (cmd.evict_do) begin
                victim_reg             <= key_rdata;
                valid_reg[oldest_reg]  <= 1'b0;
                count_reg              <= count_reg - 1'b1;
                if (count_reg == CNT_W'(1)) begin
                    oldest_reg <= '0;
                    newest_reg <= '0;
                end else begin
                    oldest_reg <= newer_rdata;
                end
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg.status      <= cmd.code;
            m_data_reg.evicted_key <= victim_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sts.item_evict = (item_reg.mode == MODE_EVICT);
    assign sts.empty      = (count_reg == '0);
    assign sts.scan_last  = (scan_cnt_reg == IDX_W'(ENTRIES - 1));
    assign sts.found      = found_reg;
    assign sts.have_free  = have_free_reg;
    assign sts.hit_newest = (hit_reg == newest_reg);
    assign sts.out_free   = out_free;

endmodule

@@ design/lrt_ctrl.sv @@
// Controller state machine of the LRU replacement tracker.
module lrt_ctrl
    import lrt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  lrt_sts_t sts,
    output lrt_cmd_t cmd
);

    lrt_state_t state_reg;
    lrt_state_t state_next;
    logic [2:0] code_reg;
    logic [2:0] code_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            code_reg  <= ST_HIT;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!sts.item_evict) begin
                    state_next = S_SCAN;
                end else if (sts.empty) begin
                    code_next  = ST_EMPTY;
                    state_next = S_RESPOND;
                end else begin
                    state_next = S_EV_RD;
                end
            end
            S_SCAN: begin
                if (sts.scan_last) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (sts.found) begin
                    if (sts.hit_newest) begin
                        code_next  = ST_HIT;
                        state_next = S_RESPOND;
                    end else begin
                        state_next = S_LINK_RD;
                    end
                end else if (!sts.have_free) begin
                    code_next  = ST_FULL;
                    state_next = S_RESPOND;
                end else begin
                    state_next = S_INSERT;
                end
            end
            S_LINK_RD: begin
                state_next = S_RELINK_A;
            end
            S_RELINK_A: begin
                state_next = S_RELINK_B;
            end
            S_RELINK_B: begin
                code_next  = ST_HIT;
                state_next = S_RESPOND;
            end
            S_INSERT: begin
                code_next  = ST_INSERTED;
                state_next = S_RESPOND;
            end
            S_EV_RD: begin
                state_next = S_EV_DO;
            end
            S_EV_DO: begin
                code_next  = ST_EVICTED;
                state_next = S_RESPOND;
            end
            S_RESPOND: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.code = code_reg;
        s_ready  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
            end
            S_RELINK_A: begin
                cmd.relink_a = 1'b1;
            end
            S_RELINK_B: begin
                cmd.relink_b = 1'b1;
            end
            S_INSERT: begin
                cmd.insert = 1'b1;
            end
            S_EV_RD: begin
                cmd.evict_rd = 1'b1;
            end
            S_EV_DO: begin
                cmd.evict_do = 1'b1;
            end
            S_RESPOND: begin
                cmd.emit = sts.out_free;
            end
            default: begin
                cmd.code = code_reg;
            end
        endcase
    end

endmodule

@@ design/lru_replacement_tracker.sv @@
// Top level of the LRU replacement tracker: controller and datapath with its slot RAMs.
//
//  Channel  Direction  Ports                     Content
//  s_       in         s_valid s_ready s_data    mode, key
//  m_       out        m_valid m_ready m_data    status, evicted_key
//
// A touch scans the key RAM one slot per cycle and registers its result on a hit of the
// newest key or a full tracker; an insert first passes S_INSERT and a move of a present key
// S_LINK_RD, S_RELINK_A and S_RELINK_B. An evict passes S_EV_RD and S_EV_DO, an evict of an
// empty tracker neither. s_ready rises in the cycle after the result is registered. Reset
// clears the valid bits, the oldest and newest pointers and the count. A new result waits
// in the controller while the previous one sits unaccepted at the output.
module lru_replacement_tracker
    import lrt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  lrt_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output lrt_out_t m_data
);

    lrt_cmd_t cmd;
    lrt_sts_t sts;

    lrt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lrt_datapath #(.ENTRIES(ENTRIES)) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

@@ design/lrt_checker.sv @@
// Port-level checker of the LRU replacement tracker and its bind.
module lrt_checker
    import lrt_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input lrt_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input lrt_out_t m_data
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("Input transfer dropped before acceptance.");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result changed while stalled.");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Second item taken while one is in work.");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_HIT) || (m_data.status == ST_INSERTED) ||
            (m_data.status == ST_FULL) || (m_data.status == ST_EVICTED) ||
            (m_data.status == ST_EMPTY))
        else $error("Result carries an unknown status code.");

    a_victim_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_EVICTED) |-> (m_data.evicted_key == '0))
        else $error("Evicted key is nonzero on a result that evicted nothing.");

endmodule

bind lru_replacement_tracker lrt_checker u_lrt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ dv/lru_replacement_tracker_tb.sv @@
// Self-checking testbench of the LRU replacement tracker with a slot-list predictor.
module lru_replacement_tracker_tb;
    import lrt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = ENTRIES_DEF;
    localparam int POOL_SIZE  = 22;
    localparam int HOLD_LEN   = 300;
    localparam int IDLE_LIMIT = 2000;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    lrt_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    lrt_out_t m_data;

    logic [KEY_BITS-1:0] trk_key [DEPTH];
    bit                  trk_used [DEPTH];
    int                  trk_newer [DEPTH];
    int                  trk_older [DEPTH];
    int                  trk_oldest;
    int                  trk_newest;
    int                  trk_count;

    lrt_out_t            outcome_q [$];
    logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
    int                  errors;
    int                  idle_cycles;
    bit                  tx_steady;
    bit                  rx_steady;
    bit                  hold_req;

    lru_replacement_tracker #(
        .ENTRIES(DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic lrt_out_t lru_outcome(lrt_in_t item);
        lrt_out_t res;
        bit       found;
        bit       have_free;
        int       hit_slot;
        int       free_slot;
        int       o;
        int       n;
        int       s;
        res       = '0;
        found     = 1'b0;
        have_free = 1'b0;
        hit_slot  = 0;
        free_slot = 0;
        if (item.mode == MODE_TOUCH) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (trk_used[i]) begin
                    if (!found && trk_key[i] == item.key) begin
                        found    = 1'b1;
                        hit_slot = i;
                    end
                end else if (!have_free) begin
                    have_free = 1'b1;
                    free_slot = i;
                end
            end
            if (found) begin
                res.status = ST_HIT;
                if (hit_slot != trk_newest) begin
                    if (hit_slot == trk_oldest) begin
                        trk_oldest = trk_newer[hit_slot];
                    end else begin
                        o = trk_older[hit_slot];
                        n = trk_newer[hit_slot];
                        trk_newer[o] = n;
                        trk_older[n] = o;
                    end
                    trk_older[hit_slot]   = trk_newest;
                    trk_newer[trk_newest] = hit_slot;
                    trk_newest            = hit_slot;
                end
            end else if (!have_free || trk_count >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                trk_key[free_slot]  = item.key;
                trk_used[free_slot] = 1'b1;
                if (trk_count == 0) begin
                    trk_oldest = free_slot;
                end else begin
                    trk_older[free_slot]  = trk_newest;
                    trk_newer[trk_newest] = free_slot;
                end
                trk_newest = free_slot;
                trk_count++;
                res.status = ST_INSERTED;
            end
        end else if (trk_count == 0) begin
            res.status = ST_EMPTY;
        end else begin
            s               = trk_oldest;
            res.status      = ST_EVICTED;
            res.evicted_key = trk_key[s];
            trk_used[s]     = 1'b0;
            trk_count--;
            if (trk_count == 0) begin
                trk_oldest = 0;
                trk_newest = 0;
            end else begin
                trk_oldest = trk_newer[s];
            end
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(0, 2);
        end else if (r < 95) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (r < 88) begin
            return key_pool[$urandom_range(0, POOL_SIZE - 1)] ^ (32'h1 << $urandom_range(0, 31));
        end
        return $urandom;
    endfunction

    task automatic send_item(input logic mode, input logic [KEY_BITS-1:0] key);
        int      gap;
        lrt_in_t item;
        gap       = tx_steady ? 0 : pick_gap();
        item.mode = mode;
        item.key  = key;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        outcome_q.push_back(lru_outcome(item));
    endtask

    task automatic refresh_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end
    endtask

    task automatic run_random(input int count, input int evict_pct);
        refresh_pool();
        repeat (count) begin
            if ($urandom_range(0, 99) < evict_pct) begin
                send_item(MODE_EVICT, $urandom);
            end else begin
                send_item(MODE_TOUCH, pick_key());
            end
        end
    endtask

    task automatic test_empty_and_order();
        send_item(MODE_EVICT, 32'hFFFF_FFFF);
        send_item(MODE_TOUCH, 32'h0000_0000);
        send_item(MODE_TOUCH, 32'hFFFF_FFFF);
        send_item(MODE_TOUCH, 32'hFFFF_FFFF);
        send_item(MODE_TOUCH, 32'h0000_0000);
        send_item(MODE_TOUCH, 32'h1234_5678);
        send_item(MODE_TOUCH, 32'h0000_0000);
        repeat (3) send_item(MODE_EVICT, 32'h0000_0000);
        send_item(MODE_EVICT, 32'h0000_0000);
    endtask

    task automatic test_full_tracker();
        for (int i = 0; i < DEPTH; i++) begin
            send_item(MODE_TOUCH, {i[3:0], 28'hA5C_3E17} ^ (32'h1 << (i + 8)));
        end
        send_item(MODE_TOUCH, 32'hDEAD_0001);
        send_item(MODE_TOUCH, {4'd7, 28'hA5C_3E17} ^ (32'h1 << 15));
        send_item(MODE_TOUCH, {4'd0, 28'hA5C_3E17} ^ (32'h1 << 8));
    endtask

    task automatic test_output_stall();
        tx_steady = 1'b1;
        hold_req  = 1'b1;
        refresh_pool();
        for (int i = 0; i < 12; i++) begin
            send_item((i % 3 == 2) ? MODE_EVICT : MODE_TOUCH, pick_key());
        end
        tx_steady = 1'b0;
    endtask

    task automatic test_random_filling();
        run_random(450, 20);
    endtask

    task automatic test_random_draining();
        run_random(450, 60);
    endtask

    task automatic test_random_back_to_back();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        run_random(300, 40);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        int burst;
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_LEN) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end else begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(1, 20);
                repeat (burst) begin
                    @(negedge aclk);
                    m_ready <= 1'b1;
                end
                gap = rx_steady ? 0 : pick_gap();
                repeat (gap) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        lrt_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (outcome_q.size() == 0) begin
                $error("unexpected result transfer: status %0d evicted_key %h",
                       m_data.status, m_data.evicted_key);
                errors++;
            end else begin
                want = outcome_q.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_data.status);
                    errors++;
                end
                if (m_data.evicted_key !== want.evicted_key) begin
                    $error("evicted_key: expected %h, actual %h",
                           want.evicted_key, m_data.evicted_key);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        errors      = 0;
        idle_cycles = 0;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
        hold_req    = 1'b0;
        trk_oldest  = 0;
        trk_newest  = 0;
        trk_count   = 0;
        for (int i = 0; i < DEPTH; i++) begin
            trk_key[i]   = '0;
            trk_used[i]  = 1'b0;
            trk_newer[i] = 0;
            trk_older[i] = 0;
        end
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_and_order();
        test_full_tracker();
        test_output_stall();
        test_random_filling();
        test_random_draining();
        test_random_back_to_back();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge aclk);
        repeat (2 * DEPTH + 16) @(posedge aclk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
